// ===== src/boc_pkg.sv =====
`timescale 1ns / 1ps

package boc_pkg;

   // counter and field widths
   localparam int CHANGE_WIDTH    = 32;
   localparam int ONTIME_WIDTH    = 48;
   localparam int PERIOD_WIDTH    = 14;
   localparam int OPCODE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 14;

   // item kinds
   localparam logic [OPCODE_WIDTH-1:0] OP_TICK    = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_COMMAND = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_TOGGLE  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_ESTOP   = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_INIT    = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIN_INVERT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_LEVEL  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_PERIOD   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_PERIOD  = 2'd3;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic                    has_state;
      logic                    state_value;
      logic                    has_blink;
      logic                    blink_value;
   } item_type;

   typedef struct packed {
      logic                    pin_level;
      logic                    logical_on;
      logic                    is_blinking;
      logic [CHANGE_WIDTH-1:0] change_count;
      logic [ONTIME_WIDTH-1:0] on_time_ms;
   } result_type;

   typedef struct packed {
      logic                    pin_invert;
      logic                    init_level;
      logic [PERIOD_WIDTH-1:0] on_period_ms;
      logic [PERIOD_WIDTH-1:0] off_period_ms;
   } cfg_type;

   typedef struct packed {
      logic                    current_on;
      logic                    commanded_on;
      logic                    blink_enabled;
      logic                    phase_on;
      logic [PERIOD_WIDTH-1:0] phase_elapsed;
      logic [CHANGE_WIDTH-1:0] changes;
      logic [ONTIME_WIDTH-1:0] on_ticks;
   } state_type;

endpackage

// ===== src/boc_if.sv =====
`timescale 1ns / 1ps

// request channel
interface boc_req_if;
   import boc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic                    has_state;
   logic                    state_value;
   logic                    has_blink;
   logic                    blink_value;

   modport source (output valid, opcode, has_state, state_value, has_blink, blink_value,
                   input ready);
   modport sink   (input valid, opcode, has_state, state_value, has_blink, blink_value,
                   output ready);
endinterface

// response channel
interface boc_rsp_if;
   import boc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    pin_level;
   logic                    logical_on;
   logic                    is_blinking;
   logic [CHANGE_WIDTH-1:0] change_count;
   logic [ONTIME_WIDTH-1:0] on_time_ms;

   modport source (output valid, pin_level, logical_on, is_blinking, change_count,
                   on_time_ms, input ready);
   modport sink   (input valid, pin_level, logical_on, is_blinking, change_count,
                   on_time_ms, output ready);
endinterface

// register write channel
interface boc_csr_if;
   import boc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/boc_csr.sv =====
`timescale 1ns / 1ps

module boc_csr (
   input  logic             clock,
   input  logic             reset,
   boc_csr_if.sink          csr_chan,
   output boc_pkg::cfg_type cfg
);
   import boc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_chan.ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PIN_INVERT:  cfg_in.pin_invert    = csr_chan.data[0];
            CSR_INIT_LEVEL:  cfg_in.init_level    = csr_chan.data[0];
            CSR_ON_PERIOD:   cfg_in.on_period_ms  = csr_chan.data[PERIOD_WIDTH-1:0];
            CSR_OFF_PERIOD:  cfg_in.off_period_ms = csr_chan.data[PERIOD_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/boc_engine.sv =====
`timescale 1ns / 1ps

module boc_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  boc_pkg::item_type   item,
   input  boc_pkg::cfg_type    cfg,
   output boc_pkg::result_type result_in
);
   import boc_pkg::*;

   state_type               state_ff;
   state_type               state_in;
   logic [PERIOD_WIDTH-1:0] elapsed_sat;
   logic [PERIOD_WIDTH-1:0] tick_elapsed;
   logic [PERIOD_WIDTH-1:0] cur_period;
   logic                    periods_set;
   logic                    phase_done;
   logic                    apply_req;
   logic                    apply_val;

   // blink phase counter, saturating
   assign elapsed_sat  = (state_ff.phase_elapsed == '1) ? state_ff.phase_elapsed
                                                        : state_ff.phase_elapsed + 1'b1;
   assign tick_elapsed = state_ff.blink_enabled ? elapsed_sat : state_ff.phase_elapsed;
   assign periods_set  = (cfg.on_period_ms != '0) && (cfg.off_period_ms != '0);
   assign cur_period   = state_ff.phase_on ? cfg.on_period_ms : cfg.off_period_ms;
   assign phase_done   = state_ff.blink_enabled && periods_set && (tick_elapsed >= cur_period);

   // next state per item kind
   always_comb begin
      state_in  = state_ff;
      apply_req = 1'b0;
      apply_val = 1'b0;
      if (step) begin
         case (item.opcode)
            OP_TICK: begin
               state_in.phase_elapsed = tick_elapsed;
               if (phase_done) begin
                  state_in.phase_on      = ~state_ff.phase_on;
                  state_in.phase_elapsed = '0;
                  apply_req              = 1'b1;
                  apply_val              = ~state_ff.phase_on;
               end
               // the millisecond counts as on if it started on
               if (state_ff.current_on) begin
                  state_in.on_ticks = state_ff.on_ticks + 1'b1;
               end
            end
            OP_COMMAND: begin
               if (item.has_state) begin
                  state_in.commanded_on  = item.state_value;
                  state_in.blink_enabled = 1'b0;
               end
               if (item.has_blink) begin
                  state_in.blink_enabled = item.blink_value;
                  if (item.blink_value) begin
                     state_in.phase_elapsed = '0;
                  end
               end
               apply_req = ~state_in.blink_enabled;
               apply_val = state_in.commanded_on;
            end
            OP_TOGGLE: begin
               state_in.commanded_on  = ~state_ff.current_on;
               state_in.blink_enabled = 1'b0;
               apply_req              = 1'b1;
               apply_val              = ~state_ff.current_on;
            end
            OP_ESTOP: begin
               state_in.commanded_on  = 1'b0;
               state_in.blink_enabled = 1'b0;
               apply_req              = 1'b1;
               apply_val              = 1'b0;
            end
            OP_INIT: begin
               state_in.commanded_on = cfg.init_level;
               apply_req             = 1'b1;
               apply_val             = cfg.init_level;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
         // level change and change counter
         if (apply_req && (apply_val != state_ff.current_on)) begin
            state_in.current_on = apply_val;
            state_in.changes    = state_ff.changes + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result seen after the item is applied
   always_comb begin
      result_in.pin_level    = state_in.current_on ^ cfg.pin_invert;
      result_in.logical_on   = state_in.current_on;
      result_in.is_blinking  = state_in.blink_enabled;
      result_in.change_count = state_in.changes;
      result_in.on_time_ms   = state_in.on_ticks;
   end

endmodule

// ===== src/blinking_output_controller.sv =====
`timescale 1ns / 1ps
// path: input register, then result register, which offers the response beat
// throughput: one item per cycle while responses are taken; the state update between
//    the two registers is combinational, so items can follow back to back
// reset: synchronous, active high; clears the configuration registers, blink state,
//    counters and both pipeline valid flags

module blinking_output_controller (
   input  logic    clock,
   input  logic    reset,
   boc_req_if.sink   req_chan,
   boc_rsp_if.source rsp_chan,
   boc_csr_if.sink   csr_chan
);
   import boc_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result_ff;
   result_type result_in;
   cfg_type    cfg;
   logic       req_fire;
   logic       advance;

   // configuration registers
   boc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // state update
   boc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .cfg       (cfg),
      .result_in (result_in)
   );

   // handshake between input and result registers
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.opcode      <= req_chan.opcode;
         in_item_ff.has_state   <= req_chan.has_state;
         in_item_ff.state_value <= req_chan.state_value;
         in_item_ff.has_blink   <= req_chan.has_blink;
         in_item_ff.blink_value <= req_chan.blink_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pin_level    = result_ff.pin_level;
   assign rsp_chan.logical_on   = result_ff.logical_on;
   assign rsp_chan.is_blinking  = result_ff.is_blinking;
   assign rsp_chan.change_count = result_ff.change_count;
   assign rsp_chan.on_time_ms   = result_ff.on_time_ms;

`ifndef SYNTH
   // pipeline empties after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // request side stalls only when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

   // change counter moves by at most one between consecutive results
   a_change_step: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_valid_ff |=>
         (rsp_chan.change_count == $past(rsp_chan.change_count)) ||
         (rsp_chan.change_count == $past(rsp_chan.change_count) + 1'b1))
      else $error("change count jumped");

   // on-time moves by at most one between consecutive results
   a_ontime_step: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_valid_ff |=>
         (rsp_chan.on_time_ms == $past(rsp_chan.on_time_ms)) ||
         (rsp_chan.on_time_ms == $past(rsp_chan.on_time_ms) + 1'b1))
      else $error("on-time jumped");
`endif

endmodule

// ===== bench/tb_blinking_output_controller.sv =====
`timescale 1ns / 1ps

module tb_blinking_output_controller;
   import boc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned SOAK_TICKS   = 40;
   localparam logic [PERIOD_WIDTH-1:0] LONG_PERIOD     = 14'd24;
   localparam logic [OPCODE_WIDTH-1:0] OP_FIRST_UNUSED = OP_INIT + 1'b1;
   localparam logic [OPCODE_WIDTH-1:0] OP_LAST_UNUSED  = '1;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // mirror of the pin controller state, one expected beat per accepted item
   class pin_tracker_type;
      cfg_type     regs;
      state_type   st;
      result_type  expected_q[$];
      int unsigned mismatches;
      int unsigned results_checked;

      function new();
         regs = '0;
         st = '0;
         mismatches = 0;
         results_checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_PIN_INVERT:  regs.pin_invert    = data[0];
            CSR_INIT_LEVEL:  regs.init_level    = data[0];
            CSR_ON_PERIOD:   regs.on_period_ms  = data[PERIOD_WIDTH-1:0];
            CSR_OFF_PERIOD:  regs.off_period_ms = data[PERIOD_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // a level change bumps the change counter
      function void drive_level(logic level);
         if (level != st.current_on) begin
            st.current_on = level;
            st.changes = st.changes + 1'b1;
         end
      endfunction

      function void take_item(item_type it);
         logic                    was_on;
         logic [PERIOD_WIDTH-1:0] period;
         result_type              want;
         case (it.opcode)
            OP_TICK: begin
               was_on = st.current_on;
               if (st.blink_enabled) begin
                  // elapsed count saturates at all ones
                  if (st.phase_elapsed != '1)
                     st.phase_elapsed = st.phase_elapsed + 1'b1;
                  if (regs.on_period_ms != '0 && regs.off_period_ms != '0) begin
                     period = st.phase_on ? regs.on_period_ms : regs.off_period_ms;
                     if (st.phase_elapsed >= period) begin
                        st.phase_on = ~st.phase_on;
                        drive_level(st.phase_on);
                        st.phase_elapsed = '0;
                     end
                  end
               end
               if (was_on)
                  st.on_ticks = st.on_ticks + 1'b1;
            end
            OP_COMMAND: begin
               if (it.has_state) begin
                  st.commanded_on = it.state_value;
                  st.blink_enabled = 1'b0;
               end
               if (it.has_blink) begin
                  st.blink_enabled = it.blink_value;
                  if (it.blink_value)
                     st.phase_elapsed = '0;
               end
               if (!st.blink_enabled)
                  drive_level(st.commanded_on);
            end
            OP_TOGGLE: begin
               st.commanded_on = ~st.current_on;
               st.blink_enabled = 1'b0;
               drive_level(st.commanded_on);
            end
            OP_ESTOP: begin
               st.blink_enabled = 1'b0;
               drive_level(1'b0);
               st.commanded_on = 1'b0;
            end
            OP_INIT: begin
               drive_level(regs.init_level);
               st.commanded_on = regs.init_level;
            end
            default: ;
         endcase
         want.pin_level    = st.current_on ^ regs.pin_invert;
         want.logical_on   = st.current_on;
         want.is_blinking  = st.blink_enabled;
         want.change_count = st.changes;
         want.on_time_ms   = st.on_ticks;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing pending, expected none got %p",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         compare_field("pin_level", want.pin_level, got.pin_level);
         compare_field("logical_on", want.logical_on, got.logical_on);
         compare_field("is_blinking", want.is_blinking, got.is_blinking);
         compare_field("change_count", want.change_count, got.change_count);
         compare_field("on_time_ms", want.on_time_ms, got.on_time_ms);
      endfunction
   endclass

   logic clock;
   logic reset;

   boc_req_if req_if();
   boc_rsp_if rsp_if();
   boc_csr_if csr_if();

   blinking_output_controller uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   pin_tracker_type tracker;
   int unsigned     gap_pct;
   int unsigned     stall_pct;
   int unsigned     items_sent;
   int unsigned     random_sent;
   int unsigned     reg_writes;
   int unsigned     cycles;

   function automatic item_type make_item(logic [OPCODE_WIDTH-1:0] op, logic hs, logic sv,
                                          logic hb, logic bv);
      item_type it;
      it.opcode      = op;
      it.has_state   = hs;
      it.state_value = sv;
      it.has_blink   = hb;
      it.blink_value = bv;
      return it;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[blinking_output_controller] ERROR");
      $finish;
   end

   // request monitor: every accepted beat feeds the tracker
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && req_if.valid && req_if.ready)
            tracker.take_item(make_item(req_if.opcode, req_if.has_state, req_if.state_value,
                                        req_if.has_blink, req_if.blink_value));
      end
   end

   // response side: check accepted beats, then pick the next ready
   initial begin
      result_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.pin_level    = rsp_if.pin_level;
            got.logical_on   = rsp_if.logical_on;
            got.is_blinking  = rsp_if.is_blinking;
            got.change_count = rsp_if.change_count;
            got.on_time_ms   = rsp_if.on_time_ms;
            tracker.check_result(got);
         end
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // mostly ticks and blink-friendly commands, some noise
   function automatic item_type rand_item();
      item_type    it;
      int unsigned pick;
      it = item_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
         it.opcode = OP_TICK;
      end else if (pick < 78) begin
         it.opcode = OP_COMMAND;
         it.has_state = ($urandom_range(99) < 30);
         it.has_blink = ($urandom_range(99) < 60);
         it.blink_value = ($urandom_range(99) < 75);
      end else if (pick < 85) begin
         it.opcode = OP_TOGGLE;
      end else if (pick < 89) begin
         it.opcode = OP_ESTOP;
      end else if (pick < 95) begin
         it.opcode = OP_INIT;
      end else begin
         it.opcode = OPCODE_WIDTH'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      end
      return it;
   endfunction

   function automatic void set_idle(idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin gap_pct = 51; stall_pct = 0;  end
         IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 51; end
         IDLE_BOTH:     begin gap_pct = 14; stall_pct = 14; end
         default:       begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endfunction

   // one request beat, with a random gap in front
   task automatic send_item(input item_type it);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= it.opcode;
      req_if.has_state   <= it.has_state;
      req_if.state_value <= it.state_value;
      req_if.has_blink   <= it.has_blink;
      req_if.blink_value <= it.blink_value;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // hold off the sender until every pending beat is back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_INDEX_WIDTH-1:0] index,
                           input logic [CSR_DATA_WIDTH-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      tracker.write_reg(index, data);
      reg_writes++;
   endtask

   // register writes only once the block is idle
   task automatic program_regs(input logic al, input logic ds,
                               input logic [PERIOD_WIDTH-1:0] on_p,
                               input logic [PERIOD_WIDTH-1:0] off_p);
      wait_drained();
      csr_beat(CSR_PIN_INVERT, CSR_DATA_WIDTH'(al));
      csr_beat(CSR_INIT_LEVEL, CSR_DATA_WIDTH'(ds));
      csr_beat(CSR_ON_PERIOD, CSR_DATA_WIDTH'(on_p));
      csr_beat(CSR_OFF_PERIOD, CSR_DATA_WIDTH'(off_p));
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      int unsigned             per_phase;
      logic [PERIOD_WIDTH-1:0] on_p;
      logic [PERIOD_WIDTH-1:0] off_p;
      tracker = new();
      items_sent = 0;
      random_sent = 0;
      reg_writes = 0;
      reset <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= OP_TICK;
      req_if.has_state   <= 1'b0;
      req_if.state_value <= 1'b0;
      req_if.has_blink   <= 1'b0;
      req_if.blink_value <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_PIN_INVERT;
      csr_if.data  <= '0;
      set_idle(IDLE_BOTH);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, periods zero
      send_item(make_item(OP_INIT, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(OP_COMMAND, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(make_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_TOGGLE, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_TOGGLE, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(OP_ESTOP, 1'b0, 1'b0, 1'b0, 1'b0));
      // blinking with zero periods never flips
      send_item(make_item(OP_COMMAND, 1'b0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(OP_COMMAND, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_COMMAND, 1'b1, 1'b1, 1'b1, 1'b1));
      // unknown opcodes leave the state alone
      send_item(make_item(OP_FIRST_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(OP_LAST_UNUSED, 1'b1, 1'b0, 1'b1, 1'b0));
      send_item(make_item(OP_COMMAND, 1'b0, 1'b0, 1'b1, 1'b0));
      send_item(make_item(OP_COMMAND, 1'b1, 1'b0, 1'b0, 1'b0));

      // directed: inverted pin, default on, short periods
      program_regs(1'b1, 1'b1, 14'd1, 14'd2);
      send_item(make_item(OP_INIT, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_COMMAND, 1'b0, 1'b0, 1'b1, 1'b1));
      repeat (6) send_item(make_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_TOGGLE, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_ESTOP, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(OP_FIRST_UNUSED + 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));

      // random phases over several register settings and idle modes
      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin on_p = 14'd1; off_p = 14'd1; end
            1:       begin on_p = '0;    off_p = 14'd4; end
            2:       begin on_p = 14'd5; off_p = '0;    end
            default: begin
               on_p  = PERIOD_WIDTH'($urandom_range(8, 1));
               off_p = PERIOD_WIDTH'($urandom_range(8, 1));
            end
         endcase
         program_regs(ph[0], ph[1], on_p, off_p);
         set_idle(idle_mode_type'(ph % 4));
         for (int n = 0; n < per_phase; n++) begin
            send_item(rand_item());
            random_sent++;
            if (n == per_phase / 2 || $urandom_range(99) == 0)
               wait_drained();
         end
      end

      // blink soak: elapsed count runs past the periods written afterwards
      set_idle(IDLE_NONE);
      program_regs(1'b0, 1'b1, '0, '0);
      send_item(make_item(OP_COMMAND, 1'b0, 1'b0, 1'b1, 1'b1));
      repeat (SOAK_TICKS) send_item(make_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
      program_regs(1'b1, 1'b0, LONG_PERIOD, LONG_PERIOD);
      repeat (2 * LONG_PERIOD + 1)
         send_item(make_item(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(OP_ESTOP, 1'b0, 1'b0, 1'b0, 1'b0));

      wait_drained();
      repeat (4) @(posedge clock);
      $display("run covered %0d items (%0d random, rest directed and blink soak), %0d csr writes",
               items_sent, random_sent, reg_writes);
      $display("%0d result beats checked, %0d mismatches", tracker.results_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("[blinking_output_controller] OK");
      else
         $display("[blinking_output_controller] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/boc_pkg.sv
src/boc_if.sv
src/boc_csr.sv
src/boc_engine.sv
src/blinking_output_controller.sv
bench/tb_blinking_output_controller.sv
